// ===== rtl/core/chte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int SLOTS_DEF      = 4096;
  localparam int KEY_WIDTH_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int HASH_W   = 32;
  localparam int TS_W     = 12;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;
  localparam logic [TS_W-1:0] TS_RESET = 12'd1039;

  // remainder unit retires this many dividend bits per cycle
  localparam int MOD_BITS  = 2;
  localparam int MOD_STEPS = HASH_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic            done;
    logic [TS_W-1:0] rem;
  } mod_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/chained_hash_table_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Key-value table with home slots and linked overflow slots in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: lookup or insert,
//   with a signed hash, a key and write data. Output channel
//   (out_valid/out_ready) returns one result per request: status, read data
//   and the entry and collision counts after the request.
//   cfg_we writes the home slot count; the write clears the table and counts.
//   Steps after the accept: the hash remainder (operand load, then two bits
//   per cycle), a RAM read and a check for each chain slot visited, an extra
//   write when an overflow slot is linked, and the load of the output
//   register, which waits while the receiver stalls.
//   One request is in flight at a time; in_ready rises with out_valid, so
//   the engine takes no new request until the last result is in the output
//   register. After reset and after each cfg_we write the slot RAM is swept,
//   one slot per cycle, through all SLOTS slots; in_ready stays low meanwhile.
//   When the receiver stalls the result holds in the output register and the
//   next result waits in the engine until the register frees.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
  parameter int SLOTS      = chte_pkg::SLOTS_DEF,
  parameter int KEY_WIDTH  = chte_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = chte_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic signed [chte_pkg::HASH_W-1:0] in_hash_value,
  input  wire logic [KEY_WIDTH-1:0]          in_key,
  input  wire logic [DATA_WIDTH-1:0]         in_write_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [chte_pkg::STATUS_W-1:0]      out_status,
  output logic [DATA_WIDTH-1:0]              out_read_data,
  output logic [chte_pkg::CNT_W-1:0]         out_entry_count,
  output logic [chte_pkg::CNT_W-1:0]         out_collision_count,
  input  wire logic                          cfg_we,
  input  wire logic [chte_pkg::TS_W-1:0]     cfg_wdata
);
  import chte_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int RW = 1 + KEY_WIDTH + DATA_WIDTH + AW;
  // entry word layout: {used, key, data, next}
  localparam int NX_LO  = 0;
  localparam int DAT_LO = AW;
  localparam int KEY_LO = AW + DATA_WIDTH;
  localparam int USED_B = AW + DATA_WIDTH + KEY_WIDTH;
  localparam logic [AW:0] SLOTS_X = (AW+1)'(SLOTS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_LINK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  function automatic logic [TS_W-1:0] eff_size(input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] s;
    s = (ts == '0) ? TS_W'(1) : ts;
    if (32'(s) > 32'(SLOTS - 1)) begin
      s = TS_W'(SLOTS - 1);
    end
    return s;
  endfunction

  state_t          state_r, state_nxt;
  logic [TS_W-1:0] ts_r, ts_nxt;
  logic [AW:0]     next_free_r, next_free_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [CNT_W-1:0] ovf_r, ovf_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic [AW-1:0]   link_addr_r, link_addr_nxt;

  logic                  req_ins_r, req_ins_nxt;
  logic [KEY_WIDTH-1:0]  req_key_r, req_key_nxt;
  logic [DATA_WIDTH-1:0] req_data_r, req_data_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]      out_ent_r, out_ent_nxt;
  logic [CNT_W-1:0]      out_col_r, out_col_nxt;

  logic              in_acc;
  logic [HASH_W-1:0] hash_u, hash_mag;
  mod_res_t          mod_res;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic                  rd_used;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         rd_next;
  logic                  nx_ok, full;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign hash_u   = HASH_W'(in_hash_value);
  // magnitude; the most negative value wraps to 2^31, which is its magnitude
  assign hash_mag = hash_u[HASH_W-1] ? (HASH_W'(0) - hash_u) : hash_u;

  chte_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (hash_mag),
    .divisor  (eff_size(ts_r)),
    .res      (mod_res)
  );

  chte_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_used = ram_rdata[USED_B];
  assign rd_key  = ram_rdata[KEY_LO +: KEY_WIDTH];
  assign rd_data = ram_rdata[DAT_LO +: DATA_WIDTH];
  assign rd_next = ram_rdata[NX_LO +: AW];
  // successor must lie above the current slot and inside the store
  assign nx_ok   = (rd_next != '0) && (rd_next > pos_r) && ({1'b0, rd_next} < SLOTS_X);
  assign full    = (next_free_r >= SLOTS_X);

  assign ram_re    = (state_r == S_READ);
  assign ram_raddr = pos_r;

  always_comb begin
    state_nxt      = state_r;
    ts_nxt         = ts_r;
    next_free_nxt  = next_free_r;
    stored_nxt     = stored_r;
    ovf_nxt        = ovf_r;
    clr_cnt_nxt    = clr_cnt_r;
    pos_nxt        = pos_r;
    link_addr_nxt  = link_addr_r;
    req_ins_nxt    = req_ins_r;
    req_key_nxt    = req_key_r;
    req_data_nxt   = req_data_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_ent_nxt    = out_ent_r;
    out_col_nxt    = out_col_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_ins_nxt  = in_req_type;
          req_key_nxt  = in_key;
          req_data_nxt = in_write_data;
          state_nxt    = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_res.done) begin
          pos_nxt   = AW'(mod_res.rem);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        res_data_nxt = '0;
        state_nxt    = S_DONE;
        if (!rd_used) begin
          if (req_ins_r) begin
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, req_key_r, req_data_r, AW'(0)};
            stored_nxt     = stored_r + 1'b1;
            res_status_nxt = ST_INSERTED;
          end else begin
            res_status_nxt = ST_MISS;
          end
        end else if (rd_key == req_key_r) begin
          res_status_nxt = ST_FOUND;
          if (req_ins_r) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, rd_key, req_data_r, rd_next};
          end else begin
            res_data_nxt = rd_data;
          end
        end else if (nx_ok) begin
          pos_nxt   = rd_next;
          state_nxt = S_READ;
        end else if (!req_ins_r) begin
          res_status_nxt = ST_MISS;
        end else if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          // link tail to a fresh overflow slot, fill it next cycle
          ram_we         = 1'b1;
          ram_wdata      = {1'b1, rd_key, rd_data, next_free_r[AW-1:0]};
          link_addr_nxt  = next_free_r[AW-1:0];
          next_free_nxt  = next_free_r + 1'b1;
          ovf_nxt        = ovf_r + 1'b1;
          stored_nxt     = stored_r + 1'b1;
          res_status_nxt = ST_INSERTED;
          state_nxt      = S_LINK;
        end
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = link_addr_r;
        ram_wdata = {1'b1, req_key_r, req_data_r, AW'(0)};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_ent_nxt    = stored_r;
          out_col_nxt    = ovf_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (cfg_we) begin
      ts_nxt        = cfg_wdata;
      next_free_nxt = (AW+1)'(eff_size(cfg_wdata)) + 1'b1;
      stored_nxt    = '0;
      ovf_nxt       = '0;
      clr_cnt_nxt   = '0;
      state_nxt     = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ts_r        <= TS_RESET;
      next_free_r <= (AW+1)'(eff_size(TS_RESET)) + 1'b1;
      stored_r    <= '0;
      ovf_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ts_r        <= ts_nxt;
      next_free_r <= next_free_nxt;
      stored_r    <= stored_nxt;
      ovf_r       <= ovf_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    link_addr_r  <= link_addr_nxt;
    req_ins_r    <= req_ins_nxt;
    req_key_r    <= req_key_nxt;
    req_data_r   <= req_data_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_ent_r    <= out_ent_nxt;
    out_col_r    <= out_col_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_data       = out_data_r;
  assign out_entry_count     = out_ent_r;
  assign out_collision_count = out_col_r;

endmodule
`default_nettype wire

// ===== rtl/core/chte_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chte_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/chte_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chte_mod
// Iterative remainder unit: dividend modulo a 12-bit divisor, two bits a cycle.
// ----------------------------------------------------------------------------
module chte_mod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [chte_pkg::HASH_W-1:0] dividend,
  input  wire logic [chte_pkg::TS_W-1:0]  divisor,
  output chte_pkg::mod_res_t              res
);
  import chte_pkg::*;

  logic [HASH_W-1:0] q_r, q_nxt;
  logic [TS_W-1:0]   rem_r, rem_nxt;
  logic [TS_W-1:0]   d_r, d_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [TS_W:0] r1, r1s, r2, r2s;

  always_comb begin
    r1  = {rem_r, q_r[HASH_W-1]};
    r1s = (r1 >= {1'b0, d_r}) ? (r1 - {1'b0, d_r}) : r1;
    r2  = {r1s[TS_W-1:0], q_r[HASH_W-2]};
    r2s = (r2 >= {1'b0, d_r}) ? (r2 - {1'b0, d_r}) : r2;
  end

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[HASH_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
      rem_nxt = r2s[TS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table engine. Lookups and inserts
// go in over a valid/ready channel while a scoreboard model of the home and
// overflow slots predicts status, read data and both counts for every
// transaction. Directed tests cover the chain corners; random phases follow
// over a spread of table sizes, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import chte_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int KEY_W       = KEY_WIDTH_DEF;
  localparam int DATA_W      = DATA_WIDTH_DEF;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int POOL_MAX    = 64;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  entries;
    logic [CNT_W-1:0]  spills;
  } table_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_req_type = 1'b0;
  logic signed [HASH_W-1:0] in_hash_value = '0;
  logic [KEY_W-1:0]         in_key = '0;
  logic [DATA_W-1:0]        in_write_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [DATA_W-1:0]        out_read_data;
  logic [CNT_W-1:0]         out_entry_count;
  logic [CNT_W-1:0]         out_collision_count;
  logic                     cfg_we = 1'b0;
  logic [TS_W-1:0]          cfg_wdata = '0;

  // scoreboard copy of the slot store
  bit                tbl_used [SLOTS];
  logic [KEY_W-1:0]  tbl_key  [SLOTS];
  logic [DATA_W-1:0] tbl_data [SLOTS];
  int unsigned       tbl_link [SLOTS];
  int unsigned       home_count;
  int unsigned       spare_ptr;
  int unsigned       key_total;
  int unsigned       spill_total;

  table_result_t pending_results[$];

  logic [KEY_W-1:0]  pool_key  [POOL_MAX];
  logic [HASH_W-1:0] pool_hash [POOL_MAX];
  int                pool_len;

  int errors      = 0;
  int reqs_sent   = 0;
  int sizes_tried = 0;
  int tally[4]    = '{0, 0, 0, 0};
  int send_calm   = 0;
  int sink_calm   = 0;
  int sink_stall  = 0;
  int ready_wait  = 0;
  int cycle_count = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;

  chained_hash_table_engine dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_hash_value       (in_hash_value),
    .in_key              (in_key),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .out_entry_count     (out_entry_count),
    .out_collision_count (out_collision_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------
  function automatic void table_clear(input logic [TS_W-1:0] size);
    home_count = (size == 0) ? 1 : ((size > SLOTS - 1) ? SLOTS - 1 : size);
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
    spare_ptr   = home_count + 1;
    key_total   = 0;
    spill_total = 0;
  endfunction

  function automatic void occupy(input int unsigned pos, input logic [KEY_W-1:0] key,
                                 input logic [DATA_W-1:0] wdata);
    tbl_used[pos] = 1'b1;
    tbl_key[pos]  = key;
    tbl_data[pos] = wdata;
    tbl_link[pos] = 0;
    key_total++;
  endfunction

  function automatic table_result_t table_access(input logic ins,
                                                 input logic [HASH_W-1:0] hash,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [DATA_W-1:0] wdata);
    table_result_t res;
    logic [HASH_W-1:0] mag;
    int unsigned pos;
    int unsigned succ;
    bit walking;
    mag = hash[HASH_W-1] ? (32'd0 - hash) : hash;
    pos = mag % home_count;
    res.status    = ST_MISS;
    res.read_data = '0;
    walking = 1'b1;
    while (walking) begin
      walking = 1'b0;
      if (!tbl_used[pos]) begin
        if (ins) begin
          occupy(pos, key, wdata);
          res.status = ST_INSERTED;
        end
      end else if (tbl_key[pos] == key) begin
        if (ins) tbl_data[pos] = wdata;
        else res.read_data = tbl_data[pos];
        res.status = ST_FOUND;
      end else begin
        succ = tbl_link[pos];
        // a link that does not climb or leaves the store ends the chain
        if (succ != 0 && succ > pos && succ < SLOTS) begin
          pos = succ;
          walking = 1'b1;
        end else if (ins) begin
          if (spare_ptr >= SLOTS) begin
            res.status = ST_FULL;
          end else begin
            tbl_link[pos] = spare_ptr;
            occupy(spare_ptr, key, wdata);
            spare_ptr++;
            spill_total++;
            res.status = ST_INSERTED;
          end
        end
      end
    end
    res.entries = key_total[CNT_W-1:0];
    res.spills  = spill_total[CNT_W-1:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  task automatic issue_req(input logic ins, input logic [HASH_W-1:0] hash,
                           input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] wdata);
    int gap;
    bit taken;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= ins;
    in_hash_value <= hash;
    in_key        <= key;
    in_write_data <= wdata;
    // sample in_ready mid-cycle so the coming edge is known to take the transaction
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(table_access(ins, hash, key, wdata));
    reqs_sent++;
  endtask

  // drop valid and hold until every outstanding result is back
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_home_slots(input logic [TS_W-1:0] size);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_clear(size);
    sizes_tried++;
  endtask

  // keys with fixed hashes; about half alias onto a few home slots
  task automatic build_key_pool(input int unsigned size);
    int unsigned eff;
    logic [HASH_W-1:0] h;
    eff = (size == 0) ? 1 : size;
    pool_len = $urandom_range(16, POOL_MAX);
    for (int i = 0; i < pool_len; i++) begin
      pool_key[i] = {$urandom, $urandom};
      if ($urandom_range(0, 1)) begin
        h = $urandom_range(0, 7) % eff + eff * $urandom_range(0, 400000);
        if ($urandom_range(0, 1)) h = 32'd0 - h;
      end else begin
        h = $urandom;
      end
      pool_hash[i] = h;
    end
  endtask

  task automatic random_request();
    int r;
    int idx;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, pool_len - 1);
    if (r < 80)
      issue_req(1'($urandom_range(0, 1)), pool_hash[idx], pool_key[idx], $urandom);
    else if (r < 90)
      issue_req(1'($urandom_range(0, 1)), $urandom, pool_key[idx], $urandom);
    else
      issue_req(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom}, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side and result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_wait <= 0;
      hold_seen  <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      out_ready  <= 1'b0;
      ready_wait <= LONG_HOLD;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= (ready_wait == 1);
    end else if (out_valid && out_ready) begin
      sink_stall = pick_gap(sink_calm);
      ready_wait <= sink_stall;
      out_ready  <= (sink_stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual status %0d",
                 $time, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("read_data", 32'(want.read_data), 32'(out_read_data));
        check_field("entry_count", 32'(want.entries), 32'(out_entry_count));
        check_field("collision_count", 32'(want.spills), 32'(out_collision_count));
        tally[out_status]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_chain_basics();
    // reset size 1039: slots 0, 1040 and 1041 form one chain
    issue_req(REQ_LOOKUP, 32'd0, 64'd0, 32'd0);
    issue_req(REQ_INSERT, 32'd0, 64'd0, 32'd0);
    issue_req(REQ_INSERT, 32'd1039, {KEY_W{1'b1}}, {DATA_W{1'b1}});
    issue_req(REQ_INSERT, 32'd2078, 64'd3, 32'h1234_5678);
    issue_req(REQ_LOOKUP, -32'sd1039, {KEY_W{1'b1}}, 32'd0);
    issue_req(REQ_LOOKUP, 32'd0, 64'd3, 32'hFFFF_FFFF);
    issue_req(REQ_INSERT, 32'd0, 64'd0, 32'hA5A5_A5A5);
    issue_req(REQ_LOOKUP, 32'd0, 64'd5, 32'd0);
    issue_req(REQ_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 32'h5A5A_5A5A);
    issue_req(REQ_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0000, 32'd0);
    issue_req(REQ_LOOKUP, 32'h7FFF_FFFF, 64'd1, 32'd0);
  endtask

  task automatic test_single_home();
    // size zero acts as one home slot: every hash lands on slot 0
    set_home_slots(12'd0);
    issue_req(REQ_INSERT, $urandom, 64'd11, 32'd1);
    issue_req(REQ_INSERT, $urandom, 64'd12, 32'd2);
    issue_req(REQ_INSERT, $urandom, 64'd13, 32'd3);
    issue_req(REQ_INSERT, $urandom, 64'd12, 32'd22);
    issue_req(REQ_LOOKUP, $urandom, 64'd13, 32'd0);
    issue_req(REQ_LOOKUP, $urandom, 64'd12, 32'd0);
    issue_req(REQ_LOOKUP, $urandom, 64'd14, 32'd0);
  endtask

  task automatic test_clamped_size();
    // 4095 home slots leave no overflow room at all
    set_home_slots(12'hFFF);
    issue_req(REQ_INSERT, 32'd4094, 64'hAAAA, 32'd7);
    issue_req(REQ_INSERT, -32'sd8189, 64'hBBBB, 32'd8);
    issue_req(REQ_LOOKUP, 32'd4094, 64'hBBBB, 32'd0);
    issue_req(REQ_INSERT, 32'd0, 64'hBBBB, 32'd9);
    issue_req(REQ_INSERT, 32'd4094, 64'hAAAA, 32'd10);
  endtask

  task automatic test_store_full();
    // one overflow slot, then the store is exhausted
    set_home_slots(12'd4094);
    issue_req(REQ_INSERT, 32'd5, 64'h1, 32'h11);
    issue_req(REQ_INSERT, 32'd4099, 64'h2, 32'h22);
    issue_req(REQ_INSERT, 32'd5, 64'h3, 32'h33);
    issue_req(REQ_LOOKUP, 32'd5, 64'h2, 32'd0);
    issue_req(REQ_LOOKUP, 32'd5, 64'h3, 32'd0);
  endtask

  task automatic test_back_pressure();
    set_home_slots(12'd64);
    build_key_pool(64);
    // start the long hold once the sweep is over and traffic flows
    random_request();
    hold_toggle <= ~hold_toggle;
    repeat (15) random_request();
    quiesce();
    repeat (16) random_request();
  endtask

  task automatic test_random_traffic();
    logic [TS_W-1:0] size;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       size = TS_W'($urandom_range(1, 8));
        1:       size = TS_W'($urandom_range(9, 64));
        2:       size = TS_W'($urandom_range(65, 512));
        default: size = TS_W'($urandom_range(513, 4094));
      endcase
      set_home_slots(size);
      build_key_pool(size);
      repeat (205) random_request();
    end
  endtask

  initial begin
    table_clear(TS_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_chain_basics();
    test_single_home();
    test_clamped_size();
    test_store_full();
    test_back_pressure();
    test_random_traffic();
    quiesce();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d requests over %0d table sizes written after reset", reqs_sent, sizes_tried);
    $display("hits/replaces %0d, new inserts %0d, misses %0d, store full %0d",
             tally[ST_FOUND], tally[ST_INSERTED], tally[ST_MISS], tally[ST_FULL]);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/chte_pkg.sv
rtl/core/chte_ram.sv
rtl/core/chte_mod.sv
rtl/core/chained_hash_table_engine.sv
sim/tb_top.sv
